// File: src/psd_pkg.sv
// shared types and constants for the port scan detector
`timescale 1ns / 1ps
package psd_pkg;
   localparam int TABLE_ENTRIES = 128;
   localparam int PORT_SLOTS    = 16;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W = $clog2(PORT_SLOTS);
   localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int TALLY_W = $clog2(PORT_SLOTS + 1);

   localparam logic [2:0] ST_NEW     = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_REPEAT  = 3'd2;
   localparam logic [2:0] ST_ADDED   = 3'd3;
   localparam logic [2:0] ST_SETFULL = 3'd4;

   localparam logic CSR_PORT_THRESHOLD = 1'b0;
   localparam logic CSR_WINDOW_SECONDS = 1'b1;

   typedef struct packed {
      logic [31:0] source_address;
      logic [15:0] dest_port;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic       alarm;
      logic [2:0] status;
      logic [4:0] distinct_ports;
      logic [6:0] entry_index;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request beat, clear entry pointer
      logic entry_rd;   // issue read of entry at entry pointer
      logic entry_step; // advance entry pointer
      logic fetch_meta; // latch per-entry metadata, apply window check
      logic port_rd;    // issue read of port slot
      logic port_step;  // advance port pointer
      logic commit;     // write back results for a found source
      logic insert;     // write a new entry
      logic full;       // build the table full response
   } psd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic entry_left; // entry pointer below entries_used
      logic addr_hit;   // address read matches
      logic port_left;  // port pointer below tally
      logic port_hit;   // port read matches
      logic table_room; // table not full
   } psd_sts_type;
endpackage

// File: src/psd_datapath.sv
// table memories, comparators and result assembly
`timescale 1ns / 1ps
module psd_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  psd_pkg::req_type      req_data,
   input  psd_pkg::psd_cmd_type  cmd,
   input  logic [4:0]            port_threshold,
   input  logic [15:0]           window_seconds,
   output psd_pkg::psd_sts_type  sts,
   output psd_pkg::rsp_type      result
);
   import psd_pkg::*;

   logic [31:0]  addr_mem  [TABLE_ENTRIES];
   logic [31:0]  start_mem [TABLE_ENTRIES];
   logic [TALLY_W-1:0] tally_mem [TABLE_ENTRIES];
   logic         alarm_mem [TABLE_ENTRIES];
   logic [15:0]  port_mem  [TABLE_ENTRIES*PORT_SLOTS];

   req_type             req_ff;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    eptr_ff;
   logic [TALLY_W-1:0]  pptr_ff;
   logic [31:0]         addr_rd_ff, start_rd_ff;
   logic [TALLY_W-1:0]  tally_rd_ff, tally_ff;
   logic                alarm_rd_ff, alarm_ff;
   logic [15:0]         port_rd_ff;
   rsp_type             result_ff, result_in;

   logic [IDX_W-1:0]    eidx;
   logic [31:0]         diff;
   logic                expired;
   logic [TALLY_W-1:0]  tally_eff;
   logic [TALLY_W-1:0]  tally_new;
   logic                can_add, fire;

   assign eidx = eptr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.insert) begin
         used_in = used_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_data;
         eptr_ff <= '0;
      end else if (cmd.entry_step) begin
         eptr_ff <= eptr_ff + CNT_W'(1);
      end
      if (cmd.fetch_meta) begin
         pptr_ff <= '0;
      end else if (cmd.port_step) begin
         pptr_ff <= pptr_ff + TALLY_W'(1);
      end
      if (cmd.entry_rd) begin
         addr_rd_ff  <= addr_mem[eidx];
         start_rd_ff <= start_mem[eidx];
         tally_rd_ff <= tally_mem[eidx];
         alarm_rd_ff <= alarm_mem[eidx];
      end
      if (cmd.fetch_meta) begin
         tally_ff <= tally_eff;
         alarm_ff <= alarm_rd_ff;
         if (expired) begin
            start_mem[eidx] <= req_ff.now_seconds;
         end
      end
      if (cmd.port_rd) begin
         port_rd_ff <= port_mem[{eidx, pptr_ff[SLOT_W-1:0]}];
      end
      if (cmd.commit) begin
         tally_mem[eidx] <= tally_new;
         if (fire) begin
            alarm_mem[eidx] <= 1'b1;
         end
         if (can_add) begin
            port_mem[{eidx, tally_ff[SLOT_W-1:0]}] <= req_ff.dest_port;
         end
      end
      if (cmd.insert) begin
         addr_mem[used_ff[IDX_W-1:0]]  <= req_ff.source_address;
         start_mem[used_ff[IDX_W-1:0]] <= req_ff.now_seconds;
         tally_mem[used_ff[IDX_W-1:0]] <= TALLY_W'(1);
         alarm_mem[used_ff[IDX_W-1:0]] <= 1'b0;
         port_mem[{used_ff[IDX_W-1:0], {SLOT_W{1'b0}}}] <= req_ff.dest_port;
      end
      result_ff <= result_in;
   end

   // signed window compare: positive diff above window only
   assign diff    = req_ff.now_seconds - start_rd_ff;
   assign expired = !diff[31] && (diff > {16'd0, window_seconds});
   assign tally_eff = expired ? '0 : tally_rd_ff;

   assign can_add   = ({{(8-TALLY_W){1'b0}}, tally_ff} < {3'd0, port_threshold})
                      && (tally_ff < TALLY_W'(PORT_SLOTS));
   assign tally_new = can_add ? tally_ff + TALLY_W'(1) : tally_ff;
   assign fire      = ({{(8-TALLY_W){1'b0}}, tally_new} >= {3'd0, port_threshold})
                      && !alarm_ff;

   always_comb begin
      result_in = result_ff;
      if (cmd.port_step && sts.port_hit) begin
         result_in.alarm          = 1'b0;
         result_in.status         = ST_REPEAT;
         result_in.distinct_ports = 5'(tally_ff);
         result_in.entry_index    = 7'(eidx);
      end else if (cmd.commit) begin
         result_in.alarm          = fire;
         result_in.status         = can_add ? ST_ADDED : ST_SETFULL;
         result_in.distinct_ports = 5'(tally_new);
         result_in.entry_index    = 7'(eidx);
      end else if (cmd.insert) begin
         result_in.alarm          = 1'b0;
         result_in.status         = ST_NEW;
         result_in.distinct_ports = 5'd1;
         result_in.entry_index    = 7'(used_ff[IDX_W-1:0]);
      end else if (cmd.full) begin
         result_in = '{alarm: 1'b0, status: ST_FULL, distinct_ports: 5'd0,
                       entry_index: 7'd0};
      end
   end

   assign sts.entry_left = eptr_ff < used_ff;
   assign sts.addr_hit   = addr_rd_ff == req_ff.source_address;
   assign sts.port_left  = pptr_ff < tally_ff;
   assign sts.port_hit   = port_rd_ff == req_ff.dest_port;
   assign sts.table_room = used_ff < CNT_W'(TABLE_ENTRIES);
   assign result         = result_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(TABLE_ENTRIES)) else $error("entry count beyond table size");
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> sts.table_room) else $error("insert into full table");
   a_used_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> used_ff == $past(used_ff) + CNT_W'(1))
      else $error("entry count did not advance");
endmodule

// File: src/psd_controller.sv
// sequencer for table search, port search and write back
`timescale 1ns / 1ps
module psd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  psd_pkg::psd_sts_type sts,
   output psd_pkg::psd_cmd_type cmd
);
   import psd_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_EREAD = 8'b0000_0010,
      S_ECMP  = 8'b0000_0100,
      S_META  = 8'b0000_1000,
      S_PREAD = 8'b0001_0000,
      S_PCMP  = 8'b0010_0000,
      S_WRITE = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a new beat may start while the last result waits only once it is taken
   assign req_stall = !(state_ff == S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_EREAD;
            end
         end
         S_EREAD: begin
            if (sts.entry_left) begin
               cmd.entry_rd = 1'b1;
               state_in     = S_ECMP;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_ECMP: begin
            if (sts.addr_hit) begin
               state_in = S_META;
            end else begin
               cmd.entry_step = 1'b1;
               state_in       = S_EREAD;
            end
         end
         S_META: begin
            cmd.fetch_meta = 1'b1;
            state_in       = S_PREAD;
         end
         S_PREAD: begin
            if (sts.port_left) begin
               cmd.port_rd = 1'b1;
               state_in    = S_PCMP;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_PCMP: begin
            cmd.port_step = 1'b1;
            state_in      = sts.port_hit ? S_DONE : S_PREAD;
         end
         S_WRITE: begin
            if (sts.table_room) begin
               cmd.insert = 1'b1;
            end else begin
               cmd.full = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |=> rsp_valid_ff) else $error("result not presented");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(rsp_valid_ff && rsp_stall)) else $error("beat over pending result");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.commit, cmd.insert, cmd.full})) else $error("write back overlap");
endmodule

// File: src/port_scan_detector.sv
// top level of the port scan detector
//
//  channel | direction | handshake        | payload
//  req     | in        | valid / stall    | req_type
//  rsp     | out       | valid / stall    | rsp_type
//  csr     | in        | valid / ready    | index, data
//
// a known source steps through the entries before the hit, then compares its
// port slots, one memory read each; a repeated port ends the port search early.
// an unknown source or a full table first compares every entry in use.
// reset clears the entry count and control; table contents need no clearing.
// a result held by rsp_stall blocks the next request beat.
`timescale 1ns / 1ps
module port_scan_detector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psd_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psd_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import psd_pkg::*;

   logic [4:0]  port_threshold_ff;
   logic [15:0] window_seconds_ff;
   psd_cmd_type cmd;
   psd_sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_threshold_ff <= 5'd15;
         window_seconds_ff <= 16'd10;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PORT_THRESHOLD: port_threshold_ff <= csr_data[4:0];
            CSR_WINDOW_SECONDS: window_seconds_ff <= csr_data;
            default: ;
         endcase
      end
   end

   psd_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   psd_datapath u_dp (
      .clock, .reset, .req_data, .cmd,
      .port_threshold (port_threshold_ff),
      .window_seconds (window_seconds_ff),
      .sts,
      .result (rsp_data)
   );
endmodule

// File: dv/port_scan_detector_test.sv
// self-checking testbench for the port scan detector
`timescale 1ns / 1ps
module port_scan_detector_test;
   import psd_pkg::*;

   localparam int IDLE_LIMIT = 6000;
   localparam int SETTLE     = 400;
   localparam int POOL_SIZE  = 40;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [0:0] csr_index;
   logic [15:0] csr_data;

   port_scan_detector i_dut (.*);

   always #5 clock = ~clock;

   // scan table as the block should hold it
   logic [31:0] known_addr [TABLE_ENTRIES];
   logic [31:0] win_start [TABLE_ENTRIES];
   logic [4:0]  tally [TABLE_ENTRIES];
   bit          alarmed [TABLE_ENTRIES];
   logic [15:0] port_set [TABLE_ENTRIES][PORT_SLOTS];
   int          n_sources;
   logic [4:0]  thresh;
   logic [15:0] window_len;

   rsp_type     pending_rsp[$];
   int          errors;
   bit          sender_quiet;
   bit          rsp_quiet;
   bit          hold_req;
   int          rsp_wait;
   int          idle_cycles;
   logic [31:0] clock_now;
   logic [31:0] pool [POOL_SIZE];

   function automatic rsp_type scan_update(input req_type r);
      rsp_type     o;
      logic [31:0] d;
      o = '0;
      for (int i = 0; i < n_sources; i++) begin
         if (known_addr[i] == r.source_address) begin
            o.entry_index = i[6:0];
            d = r.now_seconds - win_start[i];
            if ($signed(d) > $signed({16'h0, window_len})) begin
               tally[i] = '0;
               win_start[i] = r.now_seconds;
            end
            for (int p = 0; p < tally[i]; p++) begin
               if (port_set[i][p] == r.dest_port) begin
                  o.status = ST_REPEAT;
                  o.distinct_ports = tally[i];
                  return o;
               end
            end
            if (tally[i] < thresh && tally[i] < PORT_SLOTS) begin
               port_set[i][tally[i]] = r.dest_port;
               tally[i]++;
               o.status = ST_ADDED;
            end else begin
               o.status = ST_SETFULL;
            end
            if (tally[i] >= thresh && !alarmed[i]) begin
               alarmed[i] = 1'b1;
               o.alarm = 1'b1;
            end
            o.distinct_ports = tally[i];
            return o;
         end
      end
      if (n_sources < TABLE_ENTRIES) begin
         known_addr[n_sources] = r.source_address;
         win_start[n_sources] = r.now_seconds;
         tally[n_sources] = 5'd1;
         alarmed[n_sources] = 1'b0;
         port_set[n_sources][0] = r.dest_port;
         o.status = ST_NEW;
         o.distinct_ports = 5'd1;
         o.entry_index = n_sources[6:0];
         n_sources++;
      end else begin
         o.status = ST_FULL;
      end
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic send_syn(input logic [31:0] addr, input logic [15:0] port,
                           input logic [31:0] now);
      int gap;
      req_type r;
      gap = sender_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.source_address = addr;
      r.dest_port = port;
      r.now_seconds = now;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(scan_update(r));
   endtask

   // never returns before a clock edge, so back to back calls drive at separate edges
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] val);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PORT_THRESHOLD) thresh = val[4:0];
      else window_len = val;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("unexpected result beat at %0t", $realtime);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.alarm !== want.alarm)
               report_mismatch("alarm", rsp_data.alarm, want.alarm);
            if (rsp_data.status !== want.status)
               report_mismatch("status", rsp_data.status, want.status);
            if (rsp_data.distinct_ports !== want.distinct_ports)
               report_mismatch("distinct_ports", rsp_data.distinct_ports,
                               want.distinct_ports);
            if (rsp_data.entry_index !== want.entry_index)
               report_mismatch("entry_index", rsp_data.entry_index, want.entry_index);
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 10);
      else if (rsp_wait > 0) rsp_wait--;
      if (hold_req) begin
         rsp_wait = 400;
         hold_req = 1'b0;
      end
      rsp_stall <= (rsp_wait > 0);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic test_directed();
      logic [31:0] a;
      write_csr(CSR_PORT_THRESHOLD, 16'd3);
      write_csr(CSR_WINDOW_SECONDS, 16'd10);
      a = 32'hFFFF_FFFF;
      send_syn(a, 16'h0000, 32'd100);         // new source
      send_syn(a, 16'h0000, 32'd101);         // repeated port
      send_syn(a, 16'hFFFF, 32'd102);
      send_syn(a, 16'd5, 32'd103);            // reaches threshold
      send_syn(a, 16'd6, 32'd104);            // set full, alarm only once
      send_syn(a, 16'd7, 32'd115);            // window expired
      send_syn(a, 16'hFFFF, 32'd5);           // time ran backwards
      a = 32'h0;
      send_syn(a, 16'd80, 32'hFFFF_FFFF);
      send_syn(a, 16'd81, 32'h0);             // wrap of the time counter
      send_syn(a, 16'd82, 32'h7FFF_FFFF);
      write_csr(CSR_PORT_THRESHOLD, 16'd1);
      write_csr(CSR_WINDOW_SECONDS, 16'd0);
      a = 32'h1234_5678;
      send_syn(a, 16'd1, 32'd50);             // new source skips the threshold
      send_syn(a, 16'd1, 32'd50);
      send_syn(a, 16'd2, 32'd50);
      send_syn(a, 16'd3, 32'd51);
      write_csr(CSR_PORT_THRESHOLD, 16'd0);
      write_csr(CSR_WINDOW_SECONDS, 16'hFFFF);
      a = 32'h8000_0001;
      send_syn(a, 16'd9, 32'd0);
      send_syn(a, 16'd10, 32'd1);             // zero threshold alarms at once
      send_syn(a, 16'd11, 32'd70000);
   endtask

   // threshold beyond the port slots: set stops at its limit, no alarm
   task automatic test_set_limit();
      write_csr(CSR_PORT_THRESHOLD, 16'hFFFF);
      for (int p = 0; p < PORT_SLOTS + 2; p++)
         send_syn(32'h5A5A_A5A5, 16'(p * 4099), 32'd7);
   endtask

   task automatic random_phase(input int n_items);
      int sent;
      int len;
      int k;
      logic [15:0] base_port;
      logic [31:0] a;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) == 0 && n_sources < 100) begin
            send_syn($urandom, 16'($urandom), $urandom);
            sent++;
            continue;
         end
         k = $urandom_range(0, POOL_SIZE - 1);
         a = pool[k];
         base_port = 16'($urandom);
         len = $urandom_range(1, 20);
         for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 19))
               0: clock_now = clock_now + window_len + $urandom_range(1, 40);
               1: clock_now = clock_now - $urandom_range(1, 50);
               default: clock_now = clock_now + $urandom_range(0, 2);
            endcase
            if ($urandom_range(0, 4) == 0)
               send_syn(a, base_port + 16'($urandom_range(0, j)), clock_now);
            else
               send_syn(a, base_port + 16'(j), clock_now);
            sent++;
         end
         if ($urandom_range(0, 7) == 0) wait_drained();
         sender_quiet = ($urandom_range(0, 5) == 0);
         rsp_quiet = ($urandom_range(0, 5) == 0);
      end
      sender_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   task automatic test_random();
      logic [15:0] thr_pick;
      logic [15:0] win_pick;
      for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: thr_pick = 16'd16;
            1: thr_pick = 16'd1;
            2: thr_pick = 16'd0;
            3: thr_pick = 16'($urandom_range(17, 31)) | 16'($urandom) << 5;
            default: thr_pick = 16'($urandom_range(2, 15));
         endcase
         case ($urandom_range(0, 3))
            0: win_pick = 16'd0;
            1: win_pick = 16'hFFFF;
            default: win_pick = 16'($urandom_range(1, 30));
         endcase
         write_csr(CSR_PORT_THRESHOLD, thr_pick);
         write_csr(CSR_WINDOW_SECONDS, win_pick);
         clock_now = $urandom;
         random_phase(85);
      end
   endtask

   // long receiver hold-off while the sender keeps offering beats
   task automatic test_backpressure();
      wait_drained();
      sender_quiet = 1'b1;
      hold_req = 1'b1;
      for (int i = 0; i < 12; i++)
         send_syn(pool[i % 3], 16'($urandom), clock_now + i);
      sender_quiet = 1'b0;
      wait_drained();
   endtask

   task automatic test_table_full();
      while (n_sources < TABLE_ENTRIES)
         send_syn($urandom, 16'($urandom), $urandom);
      for (int i = 0; i < 6; i++)
         send_syn($urandom, 16'($urandom), $urandom);
      send_syn(pool[0], 16'($urandom), clock_now);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      n_sources = 0;
      thresh = 5'd15;
      window_len = 16'd10;
      errors = 0;
      sender_quiet = 1'b0;
      rsp_quiet = 1'b0;
      hold_req = 1'b0;
      rsp_wait = 0;
      idle_cycles = 0;
      clock_now = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_set_limit();
      test_random();
      test_backpressure();
      test_table_full();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// File: sim.f
src/psd_pkg.sv
src/psd_datapath.sv
src/psd_controller.sv
src/port_scan_detector.sv
dv/port_scan_detector_test.sv
